[rtl/ipcr_pkg.sv]
// ----------------------------------------------------------------------------
// ipcr_pkg: shared definitions for the IPC endpoint rendezvous engine
// Field widths, command and thread state codes, and the result record.
// ----------------------------------------------------------------------------
package ipcr_pkg;

	localparam int THREADS_DEF   = 64;
	localparam int ENDPOINTS_DEF = 16;

	localparam int CMD_W      = 2;
	localparam int EP_W       = 4;
	localparam int THREAD_W   = 6;
	localparam int S_TDATA_W  = 16;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 16;
	localparam int ST_W       = 3;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CALL  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WAIT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REPLY = 2'd2;

	// Thread state codes.
	localparam logic [ST_W-1:0] ST_RUNNING = 3'd0;
	localparam logic [ST_W-1:0] ST_WAITING = 3'd1;
	localparam logic [ST_W-1:0] ST_ONRECV  = 3'd2;
	localparam logic [ST_W-1:0] ST_ONCALL  = 3'd3;
	localparam logic [ST_W-1:0] ST_ONSEND  = 3'd4;

	// One result word as it leaves the engine.
	typedef struct packed {
		logic                partner_valid;
		logic [THREAD_W-1:0] partner_thread;
		logic                partner_activated;
		logic                issuer_suspended;
		logic                error;
	} res_t;

endpackage

[rtl/ipcr_engine.sv]
// ----------------------------------------------------------------------------
// ipcr_engine: rendezvous sequencer with thread and endpoint tables
// Reads, modifies and writes back the thread table and the endpoint queue
// table, one command at a time.
// ----------------------------------------------------------------------------
module ipcr_engine #(
	parameter int THREADS   = ipcr_pkg::THREADS_DEF,
	parameter int ENDPOINTS = ipcr_pkg::ENDPOINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ipcr_pkg::CMD_W-1:0]    in_cmd,
	input  logic [ipcr_pkg::EP_W-1:0]     in_ep,
	input  logic [ipcr_pkg::THREAD_W-1:0] in_thread,
	input  logic                          in_block,
	input  logic                          in_recv,
	output logic                          res_push,
	output ipcr_pkg::res_t                res,
	input  logic                          res_ready
);

	localparam int TW        = $clog2(THREADS);
	localparam int EW        = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
	localparam int CLR_DEPTH = (THREADS > ENDPOINTS) ? THREADS : ENDPOINTS;
	localparam int CW        = $clog2(CLR_DEPTH);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DEC1 = 3'd2;
	localparam logic [2:0] S_DEC2 = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	typedef struct packed {
		logic [ipcr_pkg::ST_W-1:0] st;
		logic                      lv;
		logic [TW-1:0]             lid;
		logic [TW-1:0]             nxt;
	} tent_t;

	typedef struct packed {
		logic          ne;
		logic [TW-1:0] head;
		logic [TW-1:0] tail;
	} qend_t;

	typedef struct packed {
		qend_t cq;
		qend_t rq;
	} eent_t;

	typedef struct packed {
		logic          we;
		logic [TW-1:0] addr;
		logic          m_st;
		logic          m_link;
		logic          m_nxt;
		tent_t         d;
	} twr_t;

	function automatic qend_t q_push(qend_t q, logic [TW-1:0] t);
		qend_t r;
		r = q;
		if (q.ne) begin
			r.tail = t;
		end else begin
			r.ne   = 1'b1;
			r.head = t;
			r.tail = t;
		end
		return r;
	endfunction

	function automatic qend_t q_pop(qend_t q, logic [TW-1:0] nx);
		qend_t r;
		r = q;
		if (q.head == q.tail) begin
			r.ne = 1'b0;
		end else begin
			r.head = nx;
		end
		return r;
	endfunction

	tent_t tmem [THREADS];
	eent_t emem [ENDPOINTS];

	logic [2:0]    state_q, nxt_state;
	logic [CW-1:0] cnt_q;

	logic [ipcr_pkg::CMD_W-1:0] cmd_q;
	logic [TW-1:0]              th_q;
	logic [EW-1:0]              ep_q;
	logic                       block_q, recv_q, bad_q;
	logic [TW-1:0]              partner_q, partner_n;
	twr_t                       wb_q, wb_n, twa;
	ipcr_pkg::res_t             res_q, res_n;
	logic                       load_res;

	tent_t         t_rd_q;
	eent_t         e_rd_q;
	logic          t_re, e_re;
	logic [TW-1:0] t_raddr;
	logic          ewe;
	logic [EW-1:0] e_waddr;
	eent_t         ewd;

	logic [31:0]   in_th32, in_ep32, cnt32, pid32;
	logic [TW-1:0] in_th_idx;
	logic [EW-1:0] in_ep_idx;
	logic          in_bad, accept;

	assign in_th32   = 32'(in_thread);
	assign in_ep32   = 32'(in_ep);
	assign cnt32     = 32'(cnt_q);
	assign pid32     = 32'(partner_q);
	assign in_th_idx = in_th32[TW-1:0];
	assign in_ep_idx = in_ep32[EW-1:0];

	assign in_bad = !(in_cmd == ipcr_pkg::CMD_CALL || in_cmd == ipcr_pkg::CMD_WAIT ||
			in_cmd == ipcr_pkg::CMD_REPLY) ||
		(in_th32 >= 32'(THREADS)) ||
		((in_cmd != ipcr_pkg::CMD_REPLY) && (in_ep32 >= 32'(ENDPOINTS)));

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign e_re     = accept;
	assign res      = res_q;

	always_comb begin
		nxt_state = state_q;
		twa       = '0;
		wb_n      = '0;
		ewe       = 1'b0;
		e_waddr   = ep_q;
		ewd       = e_rd_q;
		res_n     = '0;
		load_res  = 1'b0;
		partner_n = partner_q;
		t_re      = 1'b0;
		t_raddr   = in_th_idx;
		res_push  = 1'b0;
		case (state_q)
			S_CLR: begin
				twa.we     = (cnt32 < 32'(THREADS));
				twa.addr   = cnt_q[TW-1:0];
				twa.m_st   = 1'b1;
				twa.m_link = 1'b1;
				twa.m_nxt  = 1'b1;
				twa.d      = '{st: ipcr_pkg::ST_RUNNING, lv: 1'b0, lid: '0, nxt: '0};
				ewe        = (cnt32 < 32'(ENDPOINTS));
				e_waddr    = cnt_q[EW-1:0];
				ewd        = '0;
				if (cnt32 == 32'(CLR_DEPTH - 1)) begin
					nxt_state = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					t_re      = 1'b1;
					nxt_state = S_DEC1;
				end
			end
			S_DEC1: begin
				load_res  = 1'b1;
				nxt_state = S_WB;
				if (bad_q) begin
					res_n.error = 1'b1;
				end else begin
					case (cmd_q)
						ipcr_pkg::CMD_CALL: begin
							if (t_rd_q.st != ipcr_pkg::ST_RUNNING) begin
								res_n.error = 1'b1;
							end else if (e_rd_q.rq.ne) begin
								// Fetch the oldest waiting receiver.
								partner_n = e_rd_q.rq.head;
								t_re      = 1'b1;
								t_raddr   = e_rd_q.rq.head;
								load_res  = 1'b0;
								nxt_state = S_DEC2;
							end else if (block_q) begin
								twa.we   = 1'b1;
								twa.addr = th_q;
								twa.m_st = 1'b1;
								twa.d.st = recv_q ? ipcr_pkg::ST_ONCALL : ipcr_pkg::ST_ONSEND;
								ewe      = 1'b1;
								ewd.cq   = q_push(e_rd_q.cq, th_q);
								wb_n.we    = e_rd_q.cq.ne;
								wb_n.addr  = e_rd_q.cq.tail;
								wb_n.m_nxt = 1'b1;
								wb_n.d.nxt = th_q;
								res_n.issuer_suspended = 1'b1;
							end
						end
						ipcr_pkg::CMD_WAIT: begin
							if (t_rd_q.st != ipcr_pkg::ST_RUNNING) begin
								res_n.error = 1'b1;
							end else if (e_rd_q.cq.ne) begin
								// Fetch the oldest pending caller.
								partner_n = e_rd_q.cq.head;
								t_re      = 1'b1;
								t_raddr   = e_rd_q.cq.head;
								load_res  = 1'b0;
								nxt_state = S_DEC2;
							end else begin
								twa.we   = 1'b1;
								twa.addr = th_q;
								twa.m_st = 1'b1;
								twa.d.st = ipcr_pkg::ST_WAITING;
								ewe      = 1'b1;
								ewd.rq   = q_push(e_rd_q.rq, th_q);
								wb_n.we    = e_rd_q.rq.ne;
								wb_n.addr  = e_rd_q.rq.tail;
								wb_n.m_nxt = 1'b1;
								wb_n.d.nxt = th_q;
								res_n.issuer_suspended = 1'b1;
							end
						end
						ipcr_pkg::CMD_REPLY: begin
							if (t_rd_q.lv) begin
								partner_n = t_rd_q.lid;
								t_re      = 1'b1;
								t_raddr   = t_rd_q.lid;
								load_res  = 1'b0;
								nxt_state = S_DEC2;
							end
						end
						default: begin
							res_n.error = 1'b1;
						end
					endcase
				end
			end
			S_DEC2: begin
				// The partner's entry is in t_rd_q now.
				load_res  = 1'b1;
				nxt_state = S_WB;
				case (cmd_q)
					ipcr_pkg::CMD_CALL: begin
						if (t_rd_q.st != ipcr_pkg::ST_WAITING) begin
							res_n.error = 1'b1;
						end else begin
							twa.we     = 1'b1;
							twa.addr   = partner_q;
							twa.m_st   = 1'b1;
							twa.m_link = 1'b1;
							twa.d.st   = ipcr_pkg::ST_RUNNING;
							twa.d.lv   = recv_q;
							twa.d.lid  = recv_q ? th_q : '0;
							ewe        = 1'b1;
							ewd.rq     = q_pop(e_rd_q.rq, t_rd_q.nxt);
							wb_n.we    = recv_q;
							wb_n.addr  = th_q;
							wb_n.m_st  = 1'b1;
							wb_n.d.st  = ipcr_pkg::ST_ONRECV;
							res_n.partner_valid     = 1'b1;
							res_n.partner_thread    = pid32[ipcr_pkg::THREAD_W-1:0];
							res_n.partner_activated = 1'b1;
							res_n.issuer_suspended  = recv_q;
						end
					end
					ipcr_pkg::CMD_WAIT: begin
						if (t_rd_q.st == ipcr_pkg::ST_ONCALL ||
								t_rd_q.st == ipcr_pkg::ST_ONSEND) begin
							twa.we      = 1'b1;
							twa.addr    = partner_q;
							twa.m_st    = 1'b1;
							ewe         = 1'b1;
							ewd.cq      = q_pop(e_rd_q.cq, t_rd_q.nxt);
							wb_n.we     = 1'b1;
							wb_n.addr   = th_q;
							wb_n.m_link = 1'b1;
							res_n.partner_valid  = 1'b1;
							res_n.partner_thread = pid32[ipcr_pkg::THREAD_W-1:0];
							if (t_rd_q.st == ipcr_pkg::ST_ONCALL) begin
								// The caller now waits for this receiver's reply.
								twa.d.st    = ipcr_pkg::ST_ONRECV;
								wb_n.d.lv   = 1'b1;
								wb_n.d.lid  = partner_q;
							end else begin
								twa.d.st = ipcr_pkg::ST_RUNNING;
								res_n.partner_activated = 1'b1;
							end
						end else begin
							res_n.error = 1'b1;
						end
					end
					ipcr_pkg::CMD_REPLY: begin
						if (t_rd_q.st != ipcr_pkg::ST_ONRECV) begin
							res_n.error = 1'b1;
						end else begin
							twa.we      = 1'b1;
							twa.addr    = partner_q;
							twa.m_st    = 1'b1;
							twa.d.st    = ipcr_pkg::ST_RUNNING;
							wb_n.we     = 1'b1;
							wb_n.addr   = th_q;
							wb_n.m_link = 1'b1;
							res_n.partner_valid     = 1'b1;
							res_n.partner_thread    = pid32[ipcr_pkg::THREAD_W-1:0];
							res_n.partner_activated = 1'b1;
						end
					end
					default: begin
						res_n.error = 1'b1;
					end
				endcase
			end
			S_WB: begin
				twa      = wb_q;
				res_push = 1'b1;
				nxt_state = res_ready ? S_IDLE : S_DONE;
			end
			S_DONE: begin
				res_push = 1'b1;
				if (res_ready) begin
					nxt_state = S_IDLE;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
		end else begin
			state_q <= nxt_state;
			if (state_q == S_CLR) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= in_cmd;
			th_q    <= in_th_idx;
			ep_q    <= in_ep_idx;
			block_q <= in_block;
			recv_q  <= in_recv;
			bad_q   <= in_bad;
		end
		partner_q <= partner_n;
		if (load_res) begin
			res_q <= res_n;
			wb_q  <= wb_n;
		end
	end

	// Thread table: one read port, one write port with per-field enables.
	always_ff @(posedge clk) begin
		if (t_re) begin
			t_rd_q <= tmem[t_raddr];
		end
		if (twa.we) begin
			if (twa.m_st) begin
				tmem[twa.addr].st <= twa.d.st;
			end
			if (twa.m_link) begin
				tmem[twa.addr].lv  <= twa.d.lv;
				tmem[twa.addr].lid <= twa.d.lid;
			end
			if (twa.m_nxt) begin
				tmem[twa.addr].nxt <= twa.d.nxt;
			end
		end
	end

	// Endpoint table: queue ends of both queues of an endpoint in one word.
	always_ff @(posedge clk) begin
		if (e_re) begin
			e_rd_q <= emem[in_ep_idx];
		end
		if (ewe) begin
			emem[e_waddr] <= ewd;
		end
	end

endmodule

[rtl/ipcr_out_buf.sv]
// ----------------------------------------------------------------------------
// ipcr_out_buf: result output register
// Holds one finished result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module ipcr_out_buf (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  ipcr_pkg::res_t                 res,
	output logic                           ready,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ipcr_pkg::M_TDATA_W-1:0] m_tdata
);

	logic           valid_q;
	ipcr_pkg::res_t data_q;

	assign ready    = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {6'b0, data_q.error, data_q.issuer_suspended,
		data_q.partner_activated, data_q.partner_thread, data_q.partner_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && ready) begin
			data_q <= res;
		end
	end

endmodule

[rtl/ipc_endpoint_rendezvous.sv]
// ----------------------------------------------------------------------------
// ipc_endpoint_rendezvous: synchronous IPC rendezvous engine
// Pairs callers and receivers on endpoints, keeps per-thread states and
// reply links, and reports the partner of each operation.
// ----------------------------------------------------------------------------
// The block takes one command word at a time (call, wait for caller, or
// reply) and answers each with exactly one result word. Thread states, reply
// links and queue successor links live in a thread table; the head and tail
// of every endpoint's caller and receiver queue live in an endpoint table.
// Both tables are synchronous memories with one read port and one write port
// and a registered read, so every command walks through a short
// read-modify-write sequence: it reads the issuer and its endpoint, reads
// the partner when a queue or a reply link names one, and then writes back
// the changed entries. A command that touches a partner passes through the
// states S_DEC1, S_DEC2 and S_WB, any other command through S_DEC1 and S_WB;
// the sequence follows from the two dependent table reads and the second
// thread table write. A finished result waits in an output register, so
// the next command is taken while the previous result is still unclaimed.
// If that register still holds an unclaimed word when the next result is
// finished, the engine keeps the new result and stays busy in S_DONE until
// the register frees. After reset the block runs a clearing pass over both
// tables that covers max(THREADS, ENDPOINTS) entries, 64 with the default
// sizes, with s_tready held low. A failed state check or an index out of
// range gives a result with only the error bit set and no state change.
module ipc_endpoint_rendezvous #(
	parameter int THREADS   = ipcr_pkg::THREADS_DEF,
	parameter int ENDPOINTS = ipcr_pkg::ENDPOINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [3:0] endpoint, [9:4] thread, [10] block, [11] recv, [15:12] zero
	input  logic [ipcr_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] cmd
	input  logic [ipcr_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] partner_valid, [6:1] partner_thread, [7] partner_activated,
	// [8] issuer_suspended, [9] error, [15:10] zero
	output logic [ipcr_pkg::M_TDATA_W-1:0] m_tdata
);

	logic           res_push;
	logic           res_ready;
	ipcr_pkg::res_t res;

	// Command fields unpacked from the input word.
	ipcr_engine #(
		.THREADS   (THREADS),
		.ENDPOINTS (ENDPOINTS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser[1:0]),
		.in_ep     (s_tdata[3:0]),
		.in_thread (s_tdata[9:4]),
		.in_block  (s_tdata[10]),
		.in_recv   (s_tdata[11]),
		.res_push  (res_push),
		.res       (res),
		.res_ready (res_ready)
	);

	// The output register decouples the result side from the engine.
	ipcr_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.res      (res),
		.ready    (res_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

[rtl/ipcr_checker.sv]
// ----------------------------------------------------------------------------
// ipcr_checker: port-level checks for the rendezvous engine
// Watches the stream ports of the top level and flags malformed behavior.
// ----------------------------------------------------------------------------
module ipcr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [ipcr_pkg::M_TDATA_W-1:0] m_tdata
);

	// An error result carries nothing else.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[8:0] == 9'd0 && m_tdata[15:10] == 6'd0)
		else $error("error result with other fields set");

	// Without a partner there is no partner id and no activation.
	a_no_partner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'd0)
		else $error("partner fields set without partner_valid");

	// The engine works on one command at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in progress");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

endmodule

bind ipc_endpoint_rendezvous ipcr_checker u_ipcr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
